/* hdl/ubx_receiver_fix_decoder_top_assert.svh */
// Assertion macros used by the fix decoder parser.
// No dependencies; included by the files that carry concurrent checks.
`ifndef UBX_RECEIVER_FIX_DECODER_TOP_ASSERT_SVH
`define UBX_RECEIVER_FIX_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define UBXFD_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ubx fix decoder check failed");

// Next-cycle implication, disabled while reset is low
`define UBXFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ubx fix decoder check failed");

`endif

/* hdl/ubxfd_pkg.sv */
// Shared types and constants of the UBX fix decoder.
// No dependencies; imported by the front, parser and top level.
package ubxfd_pkg;

  // Frame sync and message identifiers
  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;
  localparam logic [7:0] ClassNav   = 8'h01;
  localparam logic [7:0] IdNavSol   = 8'h06;
  localparam logic [7:0] IdNavDop   = 8'h04;

  // Minimum payload lengths and capture offsets
  localparam logic [15:0] SolMinLen    = 16'd52;
  localparam logic [15:0] DopMinLen    = 16'd18;
  localparam logic [15:0] SolTypeOff   = 16'd10;
  localparam logic [15:0] SolFlagsOff  = 16'd11;
  localparam logic [15:0] SolPdopOff   = 16'd44;
  localparam logic [15:0] SolPdopHiOff = 16'd45;
  localparam logic [15:0] SolSatsOff   = 16'd47;
  localparam logic [15:0] DopHdopOff   = 16'd12;
  localparam logic [15:0] DopHdopHiOff = 16'd13;

  // Register file
  localparam logic [15:0] MaxLenReset = 16'd1024;
  localparam logic        RegMaxLen   = 1'b0;

  // Byte queue depth (power of two, at least 2)
  localparam int unsigned QueueDepthDef = 4;

  typedef enum logic [1:0] {
    KindSol   = 2'd0,
    KindDop   = 2'd1,
    KindCkErr = 2'd2
  } result_kind_e;

  // Queued byte with its sync classification
  typedef struct packed {
    logic [7:0] data;
    logic       sync_first;
    logic       sync_second;
  } rx_entry_t;

  // One result item
  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   msg_class;
    logic [7:0]   msg_id;
    logic [7:0]   fix_type;
    logic         fix_ok;
    logic [15:0]  pdop;
    logic [15:0]  hdop;
    logic [7:0]   sats;
    logic         fix_valid;
  } result_t;

endpackage

/* hdl/ubxfd_front.sv */
// Receive front: accepts serial bytes, tags sync bytes, queues them.
// Depends on ubxfd_pkg.
module ubxfd_front #(
  parameter int unsigned QueueDepth = ubxfd_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_valid_i,
  input  logic [7:0]          rx_byte_i,
  output logic                rx_ready_o,
  output logic                head_valid_o,
  output ubxfd_pkg::rx_entry_t head_o,
  input  logic                pop_i
);
  import ubxfd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  rx_entry_t           mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q, count_d;
  logic                push;
  rx_entry_t           entry;

  // Classify the incoming byte
  always_comb begin
    entry.data        = rx_byte_i;
    entry.sync_first  = (rx_byte_i == SyncFirst);
    entry.sync_second = (rx_byte_i == SyncSecond);
  end

  assign rx_ready_o   = (count_q != CntW'(QueueDepth));
  assign push         = rx_valid_i && rx_ready_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Track fill level
  always_comb begin
    case ({push, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

  // Write queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

/* hdl/ubxfd_parser.sv */
// Frame parser: sync hunt, header, Fletcher checksum, field capture, results.
// Depends on ubxfd_pkg and the assertion macro header.
`include "ubx_receiver_fix_decoder_top_assert.svh"

module ubxfd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [15:0]          max_len_i,
  input  logic                 head_valid_i,
  input  ubxfd_pkg::rx_entry_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ubxfd_pkg::result_t   out_o
);
  import ubxfd_pkg::*;

  typedef enum logic [3:0] {
    PhHunt1, PhHunt2, PhClass, PhId, PhLenLo, PhLenHi, PhPayload, PhCkA, PhCkB
  } phase_e;

  phase_e       phase_q, phase_d;
  logic         replay_q, replay_d;
  logic [1:0]   replay_idx_q, replay_idx_d;
  logic [7:0]   class_q, class_d, id_q, id_d;
  logic [15:0]  len_q, len_d, pos_q, pos_d;
  logic [7:0]   sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [7:0]   stg_type_q, stg_type_d, stg_flags_q, stg_flags_d, stg_sats_q, stg_sats_d;
  logic [15:0]  stg_dop_q, stg_dop_d;
  logic [7:0]   fix_type_q, fix_type_d, sats_q, sats_d;
  logic         fix_ok_q, fix_ok_d, fix_valid_q, fix_valid_d;
  logic [15:0]  pdop_q, pdop_d, hdop_q, hdop_d;
  logic         out_valid_q, out_valid_d;
  result_t      out_q, out_d;
  logic [7:0]   hdr_q [4];
  logic         hdr_we;
  logic [1:0]   hdr_wa;

  logic         out_free, step;
  logic [7:0]   byte_val, sum_a_add, sum_b_add;
  logic         is_first, is_second;
  logic [15:0]  len_full, pos_inc;
  logic         is_sol, is_dop, ck_good, res_fire;
  result_kind_e res_kind;

  // Pick the byte: replayed header or queue head
  assign out_free  = !out_valid_q || out_ready_i;
  assign step      = out_free && (replay_q || head_valid_i);
  assign pop_o     = step && !replay_q;
  assign byte_val  = replay_q ? hdr_q[replay_idx_q] : head_i.data;
  assign is_first  = replay_q ? (byte_val == SyncFirst) : head_i.sync_first;
  assign is_second = replay_q ? (byte_val == SyncSecond) : head_i.sync_second;

  // Fletcher sums, length and position helpers
  assign sum_a_add = sum_a_q + byte_val;
  assign sum_b_add = sum_b_q + sum_a_add;
  assign len_full  = {byte_val, len_q[7:0]};
  assign pos_inc   = pos_q + 16'd1;
  assign is_sol    = (class_q == ClassNav) && (id_q == IdNavSol);
  assign is_dop    = (class_q == ClassNav) && (id_q == IdNavDop);
  assign ck_good   = (sum_a_q == 8'h00) && (sum_b_q == byte_val);

  // Next-state logic
  always_comb begin
    phase_d      = phase_q;
    replay_d     = replay_q;
    replay_idx_d = replay_idx_q;
    class_d      = class_q;
    id_d         = id_q;
    len_d        = len_q;
    pos_d        = pos_q;
    sum_a_d      = sum_a_q;
    sum_b_d      = sum_b_q;
    stg_type_d   = stg_type_q;
    stg_flags_d  = stg_flags_q;
    stg_dop_d    = stg_dop_q;
    stg_sats_d   = stg_sats_q;
    fix_type_d   = fix_type_q;
    fix_ok_d     = fix_ok_q;
    pdop_d       = pdop_q;
    hdop_d       = hdop_q;
    sats_d       = sats_q;
    fix_valid_d  = fix_valid_q;
    hdr_we       = 1'b0;
    hdr_wa       = 2'd0;
    res_fire     = 1'b0;
    res_kind     = KindCkErr;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    if (step) begin
      // Walk through the four replayed header bytes
      if (replay_q) begin
        replay_idx_d = replay_idx_q + 2'd1;
        if (replay_idx_q == 2'd3) begin
          replay_d = 1'b0;
        end
      end

      unique case (phase_q)
        PhHunt1: begin
          phase_d = is_first ? PhHunt2 : PhHunt1;
        end
        PhHunt2: begin
          if (is_second) begin
            phase_d     = PhClass;
            sum_a_d     = 8'h00;
            sum_b_d     = 8'h00;
            stg_type_d  = 8'h00;
            stg_flags_d = 8'h00;
            stg_dop_d   = 16'h0000;
            stg_sats_d  = 8'h00;
          end else if (!is_first) begin
            phase_d = PhHunt1;
          end
        end
        PhClass: begin
          class_d = byte_val;
          hdr_we  = 1'b1;
          hdr_wa  = 2'd0;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          phase_d = PhId;
        end
        PhId: begin
          id_d    = byte_val;
          hdr_we  = 1'b1;
          hdr_wa  = 2'd1;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_d   = {8'h00, byte_val};
          hdr_we  = 1'b1;
          hdr_wa  = 2'd2;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          phase_d = PhLenHi;
        end
        PhLenHi: begin
          len_d   = len_full;
          hdr_we  = 1'b1;
          hdr_wa  = 2'd3;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          pos_d   = 16'h0000;
          // Oversized length: drop sync, rescan the header bytes
          if (len_full > max_len_i) begin
            phase_d      = PhHunt1;
            replay_d     = 1'b1;
            replay_idx_d = 2'd0;
          end else if (len_full == 16'h0000) begin
            phase_d = PhCkA;
          end else begin
            phase_d = PhPayload;
          end
        end
        PhPayload: begin
          // Capture fix fields at their payload offsets
          if (is_sol) begin
            if (pos_q == SolTypeOff) begin
              stg_type_d = byte_val;
            end else if (pos_q == SolFlagsOff) begin
              stg_flags_d = byte_val;
            end else if (pos_q == SolPdopOff) begin
              stg_dop_d[7:0] = byte_val;
            end else if (pos_q == SolPdopHiOff) begin
              stg_dop_d[15:8] = byte_val;
            end else if (pos_q == SolSatsOff) begin
              stg_sats_d = byte_val;
            end
          end else if (is_dop) begin
            if (pos_q == DopHdopOff) begin
              stg_dop_d[7:0] = byte_val;
            end else if (pos_q == DopHdopHiOff) begin
              stg_dop_d[15:8] = byte_val;
            end
          end
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          pos_d   = pos_inc;
          if (pos_inc >= len_q) begin
            phase_d = PhCkA;
          end
        end
        PhCkA: begin
          // Fold checksum A into sum A: zero means match
          sum_a_d = sum_a_q ^ byte_val;
          phase_d = PhCkB;
        end
        PhCkB: begin
          phase_d = PhHunt1;
          if (!ck_good) begin
            res_fire = 1'b1;
            res_kind = KindCkErr;
          end else if (is_sol && (len_q >= SolMinLen)) begin
            fix_type_d  = stg_type_q;
            fix_ok_d    = stg_flags_q[0];
            pdop_d      = stg_dop_q;
            sats_d      = stg_sats_q;
            fix_valid_d = 1'b1;
            res_fire    = 1'b1;
            res_kind    = KindSol;
          end else if (is_dop && (len_q >= DopMinLen)) begin
            hdop_d      = stg_dop_q;
            fix_valid_d = 1'b1;
            res_fire    = 1'b1;
            res_kind    = KindDop;
          end
        end
        default: begin
          phase_d = PhHunt1;
        end
      endcase
    end

    // Load the output register with the updated fix
    if (res_fire) begin
      out_valid_d = 1'b1;
      out_d = '{
        kind:      res_kind,
        msg_class: class_q,
        msg_id:    id_q,
        fix_type:  fix_type_d,
        fix_ok:    fix_ok_d,
        pdop:      pdop_d,
        hdop:      hdop_d,
        sats:      sats_d,
        fix_valid: fix_valid_d
      };
    end
  end

  // Hold parser state, stored fix and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt1;
      replay_q     <= 1'b0;
      replay_idx_q <= 2'd0;
      class_q      <= 8'h00;
      id_q         <= 8'h00;
      len_q        <= 16'h0000;
      pos_q        <= 16'h0000;
      sum_a_q      <= 8'h00;
      sum_b_q      <= 8'h00;
      stg_type_q   <= 8'h00;
      stg_flags_q  <= 8'h00;
      stg_dop_q    <= 16'h0000;
      stg_sats_q   <= 8'h00;
      fix_type_q   <= 8'h00;
      fix_ok_q     <= 1'b0;
      pdop_q       <= 16'h0000;
      hdop_q       <= 16'h0000;
      sats_q       <= 8'h00;
      fix_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      replay_q     <= replay_d;
      replay_idx_q <= replay_idx_d;
      class_q      <= class_d;
      id_q         <= id_d;
      len_q        <= len_d;
      pos_q        <= pos_d;
      sum_a_q      <= sum_a_d;
      sum_b_q      <= sum_b_d;
      stg_type_q   <= stg_type_d;
      stg_flags_q  <= stg_flags_d;
      stg_dop_q    <= stg_dop_d;
      stg_sats_q   <= stg_sats_d;
      fix_type_q   <= fix_type_d;
      fix_ok_q     <= fix_ok_d;
      pdop_q       <= pdop_d;
      hdop_q       <= hdop_d;
      sats_q       <= sats_d;
      fix_valid_q  <= fix_valid_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  // Header bytes kept for the rescan after an oversized length
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_wa] <= byte_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `UBXFD_ASSERT(a_no_pop_in_replay, clk_i, rst_ni, replay_q, !pop_o)
  `UBXFD_ASSERT(a_replay_no_header_end, clk_i, rst_ni, replay_q, phase_q != PhLenHi)
  `UBXFD_ASSERT_NEXT(a_oversize_replays, clk_i, rst_ni, step && phase_q == PhLenHi && len_full > max_len_i, replay_q && replay_idx_q == 2'd0)
  `UBXFD_ASSERT(a_fix_result_valid, clk_i, rst_ni, out_valid_q && out_q.kind != KindCkErr, out_q.fix_valid)

endmodule

/* hdl/ubx_receiver_fix_decoder_top.sv */
// UBX fix decoder top: APB register, byte front queue and frame parser.
// Path: an accepted byte is written to the byte queue and reaches the parser from its head;
// out_valid_o is set from the result register once the parser takes the final checksum byte.
// Throughput: one byte per cycle; a header rescan or a held result stalls the parser,
// and during a header rescan the parser pops no bytes, so rx_ready_o drops once the queue fills.
// Reset: asynchronous, active low; parser hunts for sync, stored fix cleared, limit 1024.
module ubx_receiver_fix_decoder_top #(
  parameter int unsigned QueueDepth = ubxfd_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  message_class_o,
  output logic [7:0]  message_id_o,
  output logic [7:0]  fix_type_o,
  output logic        fix_ok_o,
  output logic [15:0] pdop_hundredths_o,
  output logic [15:0] hdop_hundredths_o,
  output logic [7:0]  satellite_count_o,
  output logic        fix_valid_o
);
  import ubxfd_pkg::*;

  logic [15:0] max_len_q;
  logic        reg_wr;
  logic        head_valid;
  rx_entry_t   head;
  logic        pop;
  result_t     res;

  // Register access
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == RegMaxLen);
  assign prdata = (paddr[2] == RegMaxLen) ? {16'h0000, max_len_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (reg_wr) begin
      max_len_q <= pwdata[15:0];
    end
  end

  ubxfd_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_byte_i    (rx_byte_i),
    .rx_ready_o   (rx_ready_o),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  ubxfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_len_i    (max_len_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res)
  );

  // Unpack the result register
  assign result_kind_o     = res.kind;
  assign message_class_o   = res.msg_class;
  assign message_id_o      = res.msg_id;
  assign fix_type_o        = res.fix_type;
  assign fix_ok_o          = res.fix_ok;
  assign pdop_hundredths_o = res.pdop;
  assign hdop_hundredths_o = res.hdop;
  assign satellite_count_o = res.sats;
  assign fix_valid_o       = res.fix_valid;

endmodule
